// ===== hdl/fca_pkg.sv =====
package fca_pkg;

    // table sizes
    localparam int NUM_BLOCKS = 1024;
    localparam int BLK_W      = $clog2(NUM_BLOCKS);
    localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);

    // port field widths, fixed by the interface
    localparam int REQ_W   = 3;
    localparam int IDX_W   = 10;
    localparam int LINK_W  = 11;
    localparam int DEPTH_W = 11;
    localparam int ST_W    = 3;

    // used map is held as rows of bits
    localparam int MAP_W    = (NUM_BLOCKS < 32) ? NUM_BLOCKS : 32;
    localparam int MAP_ROWS = NUM_BLOCKS / MAP_W;
    localparam int ROW_W    = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;
    localparam int BIT_W    = (MAP_W > 1) ? $clog2(MAP_W) : 1;

    typedef logic signed [LINK_W-1:0] t_link;

    localparam t_link LINK_END = '1;

    // request codes
    localparam logic [REQ_W-1:0] REQ_ALLOC  = REQ_W'(0);
    localparam logic [REQ_W-1:0] REQ_FREE   = REQ_W'(1);
    localparam logic [REQ_W-1:0] REQ_WALK   = REQ_W'(2);
    localparam logic [REQ_W-1:0] REQ_APPEND = REQ_W'(3);
    localparam logic [REQ_W-1:0] REQ_TRUNC  = REQ_W'(4);

    // status codes
    localparam logic [ST_W-1:0] ST_OK        = ST_W'(0);
    localparam logic [ST_W-1:0] ST_NO_FREE   = ST_W'(1);
    localparam logic [ST_W-1:0] ST_NOT_FOUND = ST_W'(2);
    localparam logic [ST_W-1:0] ST_BAD_DEPTH = ST_W'(3);
    localparam logic [ST_W-1:0] ST_EMPTY     = ST_W'(4);

    // anything negative or past the table is end of chain
    function automatic logic link_ok(t_link v);
        return !v[LINK_W-1] && (32'(v[LINK_W-2:0]) < NUM_BLOCKS);
    endfunction

endpackage

// ===== hdl/fca_ram.sv =====
module fca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/fat_chain_block_allocator_core.sv =====
// Channel   | Direction | Handshake          | Beat contents
// ----------+-----------+--------------------+------------------------------------------
// request   | in        | i_valid / o_ready  | req_type, block_index, chain_head, depth
// response  | out       | o_valid / i_ready  | status, result_block, new_head, head_changed
//
// After reset a clearing pass over NUM_BLOCKS (1024) entries sets every link to end of
// chain and every used bit to free; o_ready stays low throughout.
// One request at a time. Free reads the row in S_START, clears the bit in S_FREE;
// allocate scans one map row per S_SRCH step (32 bits a row, at most 32 rows); walk and
// truncate take one step per link; append past the end adds the scan and any tail link.
// Every link step is one read of the link RAM per cycle; the scan is one row per cycle.
// A finished beat waits in the output register; a stalled o_valid holds the sequencer
// in its last step but the request side is free once that beat is loaded.
module fat_chain_block_allocator_core
    import fca_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [REQ_W-1:0]          i_req_type,
    input  logic [IDX_W-1:0]          i_block_index,
    input  logic signed [LINK_W-1:0]  i_chain_head,
    input  logic [DEPTH_W-1:0]        i_depth,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [ST_W-1:0]           o_status,
    output logic signed [LINK_W-1:0]  o_result_block,
    output logic signed [LINK_W-1:0]  o_new_head,
    output logic                      o_head_changed
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_WALK,
        S_WALK_END,
        S_SRCH,
        S_LINK,
        S_FREE,
        S_TRUNC,
        S_OUT
    } t_state;

    t_state             r_state;
    logic [BLK_W-1:0]   r_clr;
    logic [REQ_W-1:0]   r_req;
    logic [IDX_W-1:0]   r_bidx;
    t_link              r_head;
    logic [DEPTH_W-1:0] r_depth;
    t_link              r_at;
    t_link              r_pre;
    logic [DEPTH_W-1:0] r_left;
    logic [CNT_W-1:0]   r_cnt;
    logic [ROW_W-1:0]   r_row;
    logic [BLK_W-1:0]   r_blk;

    // pending result, moved to the output register in S_OUT
    logic [ST_W-1:0]    r_st;
    t_link              r_res;
    t_link              r_nh;
    logic               r_hc;

    logic               r_o_valid;
    logic [ST_W-1:0]    r_o_status;
    t_link              r_o_res;
    t_link              r_o_nh;
    logic               r_o_hc;

    // link RAM ports
    logic               link_we;
    logic [BLK_W-1:0]   link_waddr;
    t_link              link_wdata;
    logic [BLK_W-1:0]   link_raddr;
    t_link              link_rd;

    // used-map RAM ports
    logic               map_we;
    logic [ROW_W-1:0]   map_waddr;
    logic [MAP_W-1:0]   map_wdata;
    logic [ROW_W-1:0]   map_raddr;
    logic [MAP_W-1:0]   map_rd;

    logic               w_nx_ok;
    t_link              w_nat;
    logic [DEPTH_W-1:0] w_left_n;
    logic [CNT_W-1:0]   w_cnt_n;
    logic               w_walk_more;
    logic               w_trunc_more;
    logic               w_head_ok;
    logic               w_free_any;
    logic [BIT_W-1:0]   w_zpos;
    logic [BLK_W-1:0]   w_new_blk;
    logic               w_last_row;
    logic [ROW_W-1:0]   w_bidx_row;

    function automatic logic [BIT_W-1:0] low_zero(logic [MAP_W-1:0] row);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int k = MAP_W - 1; k >= 0; k--) begin
            if (!row[k]) begin
                pos = BIT_W'(k);
            end
        end
        return pos;
    endfunction

    fca_ram #(
        .WIDTH (LINK_W),
        .DEPTH (NUM_BLOCKS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (link_raddr),
        .o_rdata (link_rd)
    );

    fca_ram #(
        .WIDTH (MAP_W),
        .DEPTH (MAP_ROWS)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_raddr (map_raddr),
        .o_rdata (map_rd)
    );

    // one link step: follow the link just read
    assign w_nx_ok      = link_ok(link_rd);
    assign w_nat        = w_nx_ok ? link_rd : LINK_END;
    assign w_left_n     = r_left - DEPTH_W'(1);
    assign w_cnt_n      = r_cnt + CNT_W'(1);
    assign w_walk_more  = w_nx_ok && (w_left_n != '0);
    assign w_trunc_more = w_nx_ok && (32'(w_cnt_n) < NUM_BLOCKS);
    assign w_head_ok    = link_ok(r_head);

    // free-bit scan of one row
    assign w_free_any = ~&map_rd;
    assign w_zpos     = low_zero(map_rd);
    assign w_new_blk  = BLK_W'({r_row, w_zpos});
    assign w_last_row = (r_row == ROW_W'(MAP_ROWS - 1));
    assign w_bidx_row = ROW_W'(r_bidx >> BIT_W);

    // RAM port steering
    always_comb begin
        link_we    = 1'b0;
        link_waddr = '0;
        link_wdata = LINK_END;
        link_raddr = '0;
        map_we     = 1'b0;
        map_waddr  = '0;
        map_wdata  = '0;
        map_raddr  = '0;
        case (r_state)
            S_CLEAR: begin
                link_we    = 1'b1;
                link_waddr = r_clr;
                map_we     = (32'(r_clr) < MAP_ROWS);
                map_waddr  = ROW_W'(r_clr);
            end
            S_START: begin
                link_raddr = r_head[BLK_W-1:0];
                if (r_req == REQ_FREE) begin
                    map_raddr = w_bidx_row;
                end
            end
            S_WALK: begin
                link_raddr = w_nat[BLK_W-1:0];
            end
            S_TRUNC: begin
                link_raddr = w_nat[BLK_W-1:0];
                // last step: cut the chain in front of the tail
                if (!w_trunc_more && link_ok(r_pre)) begin
                    link_we    = 1'b1;
                    link_waddr = r_pre[BLK_W-1:0];
                end
            end
            S_SRCH: begin
                map_raddr = r_row + ROW_W'(1);
                if (w_free_any) begin
                    map_we     = 1'b1;
                    map_waddr  = r_row;
                    map_wdata  = map_rd | (MAP_W'(1) << w_zpos);
                    link_we    = 1'b1;
                    link_waddr = w_new_blk;
                end
            end
            S_LINK: begin
                link_we    = 1'b1;
                link_waddr = r_pre[BLK_W-1:0];
                link_wdata = LINK_W'(r_blk);
            end
            S_FREE: begin
                map_we    = 1'b1;
                map_waddr = w_bidx_row;
                map_wdata = map_rd & ~(MAP_W'(1) << r_bidx[BIT_W-1:0]);
            end
            default: begin
            end
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            // S_OUT reloads the output register itself
            if (r_o_valid && i_ready && r_state != S_OUT) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + BLK_W'(1);
                    if (r_clr == BLK_W'(NUM_BLOCKS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_req   <= i_req_type;
                        r_bidx  <= i_block_index;
                        r_head  <= i_chain_head;
                        r_depth <= i_depth;
                        r_st    <= ST_NOT_FOUND;
                        r_res   <= LINK_END;
                        r_nh    <= i_chain_head;
                        r_hc    <= 1'b0;
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    case (r_req)
                        REQ_ALLOC: begin
                            r_row   <= '0;
                            r_state <= S_SRCH;
                        end
                        REQ_FREE: begin
                            r_state <= (32'(r_bidx) < NUM_BLOCKS) ? S_FREE : S_OUT;
                        end
                        REQ_WALK, REQ_APPEND: begin
                            if (r_depth == '0) begin
                                r_st    <= ST_BAD_DEPTH;
                                r_state <= S_OUT;
                            end else begin
                                r_at    <= w_head_ok ? r_head : LINK_END;
                                r_pre   <= LINK_END;
                                r_left  <= r_depth - DEPTH_W'(1);
                                r_state <= (w_head_ok && r_depth != DEPTH_W'(1)) ?
                                           S_WALK : S_WALK_END;
                            end
                        end
                        REQ_TRUNC: begin
                            if (!w_head_ok) begin
                                r_st    <= ST_EMPTY;
                                r_state <= S_OUT;
                            end else begin
                                r_at    <= r_head;
                                r_pre   <= LINK_END;
                                r_cnt   <= '0;
                                r_state <= S_TRUNC;
                            end
                        end
                        default: begin
                            r_state <= S_OUT;
                        end
                    endcase
                end
                S_WALK: begin
                    r_pre  <= r_at;
                    r_at   <= w_nat;
                    r_left <= w_left_n;
                    if (!w_walk_more) begin
                        r_state <= S_WALK_END;
                    end
                end
                S_WALK_END: begin
                    if (link_ok(r_at)) begin
                        r_st    <= ST_OK;
                        r_res   <= r_at;
                        r_state <= S_OUT;
                    end else if (r_req == REQ_WALK) begin
                        r_state <= S_OUT;
                    end else begin
                        // append past the end: r_pre holds the tail, if any
                        r_row   <= '0;
                        r_state <= S_SRCH;
                    end
                end
                S_SRCH: begin
                    if (w_free_any) begin
                        r_st  <= ST_OK;
                        r_res <= LINK_W'(w_new_blk);
                        r_blk <= w_new_blk;
                        if (r_req == REQ_APPEND && link_ok(r_pre)) begin
                            r_state <= S_LINK;
                        end else begin
                            if (r_req == REQ_APPEND) begin
                                r_nh <= LINK_W'(w_new_blk);
                                r_hc <= 1'b1;
                            end
                            r_state <= S_OUT;
                        end
                    end else if (w_last_row) begin
                        r_st    <= ST_NO_FREE;
                        r_state <= S_OUT;
                    end else begin
                        r_row <= r_row + ROW_W'(1);
                    end
                end
                S_LINK: begin
                    r_state <= S_OUT;
                end
                S_FREE: begin
                    r_st    <= ST_OK;
                    r_res   <= LINK_W'(r_bidx);
                    r_state <= S_OUT;
                end
                S_TRUNC: begin
                    r_pre <= r_at;
                    r_at  <= w_nat;
                    r_cnt <= w_cnt_n;
                    if (!w_trunc_more) begin
                        r_st  <= ST_OK;
                        r_res <= r_at;
                        // single-block chain: the chain becomes empty
                        if (!link_ok(r_pre)) begin
                            r_nh <= LINK_END;
                            r_hc <= 1'b1;
                        end
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_o_valid || i_ready) begin
                        r_o_valid  <= 1'b1;
                        r_o_status <= r_st;
                        r_o_res    <= r_res;
                        r_o_nh     <= r_nh;
                        r_o_hc     <= r_hc;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_o_valid;
    assign o_status       = r_o_status;
    assign o_result_block = r_o_res;
    assign o_new_head     = r_o_nh;
    assign o_head_changed = r_o_hc;

endmodule
